>>> rtl/core/clf_pkg.sv
// Shared types and constants of the CR/LF line framer.
package clf_pkg;

   // Default size of the line buffer; a line holds at most one byte less.
   localparam int CLF_LINE_BUFFER_BYTES = 512;

   // Result queue between front and back.
   localparam int CLF_QUEUE_DEPTH = 4;

   // Terminator bytes.
   localparam logic [7:0] CLF_CR = 8'h0D;
   localparam logic [7:0] CLF_LF = 8'h0A;

   // Register word index (paddr[2]).
   localparam logic CLF_REG_RAW_MODE = 1'b0;

   typedef enum logic [3:0] {
      PH_START   = 4'b0001,
      PH_CONTENT = 4'b0010,
      PH_RUN     = 4'b0100,
      PH_DISCARD = 4'b1000
   } clf_phase_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_line;
      logic       empty_line;
      logic       truncated;
   } clf_result_type;

   // Up to two results from one accepted byte, in order.
   typedef struct packed {
      logic [1:0]     valid;
      clf_result_type res0;
      clf_result_type res1;
   } clf_push_type;

   // Queue status seen by the front and the back.
   typedef struct packed {
      logic room;      // at least two free slots
      logic nonempty;
   } clf_qstat_type;

endpackage

>>> rtl/core/clf_channel_if.sv
// Handshake channels of the line framer: byte input and line result output.
interface clf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       chunk_end;

   modport source (output valid, output in_byte, output chunk_end, input ready);
   modport sink   (input valid, input in_byte, input chunk_end, output ready);
endinterface

interface clf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last_of_line;
   logic       empty_line;
   logic       truncated;

   modport source (output valid, output out_byte, output last_of_line,
                   output empty_line, output truncated, input ready);
   modport sink   (input valid, input out_byte, input last_of_line,
                   input empty_line, input truncated, output ready);
endinterface

>>> rtl/core/crlf_line_framer.sv
// Top level of the CR/LF line framer: register port, front, queue and back.
//
// Usage
//   req_chan: one received byte per transaction, with chunk_end on the last
//     byte of a chunk. rsp_chan: line bytes; last_of_line marks the end of
//     a line, empty_line a cooked line with no content (out_byte is zero),
//     truncated the last result of a cooked line that lost its excess.
//   APB port: one register, raw_mode, at byte address 0 (paddr[2] = 0).
//     Write it only while the block is idle. pready is always high.
//   Throughput: one byte per cycle in, one result per cycle out. A byte can
//     release up to two results; the four-entry queue absorbs them.
//   Held byte: one byte is held back to mark line ends, so a byte's
//     result is released by a later byte (or a chunk end); once released it
//     passes through the queue and the output register before it shows on
//     rsp_chan.
//   Stall: when rsp_chan.ready is low the queue fills and req_chan.ready
//     drops once fewer than two queue slots are free.
//   Reset: synchronous; clears raw_mode, framing state, held byte and queue.
module crlf_line_framer #(
   parameter int LINE_BUFFER_BYTES = clf_pkg::CLF_LINE_BUFFER_BYTES
) (
   input  logic        clock,
   input  logic        reset,
   clf_req_if.sink     req_chan,
   clf_rsp_if.source   rsp_chan,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import clf_pkg::*;

   logic           raw_mode_ff;
   logic           csr_write;
   clf_push_type   push;
   clf_qstat_type  qstat;
   clf_result_type head;
   logic           pop;

   // Register port: byte lanes ignored, word decoded on paddr[2].
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && (paddr[2] == CLF_REG_RAW_MODE);
   assign prdata    = (paddr[2] == CLF_REG_RAW_MODE) ? {31'd0, raw_mode_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_mode_ff <= 1'b0;
      end else if (csr_write) begin
         raw_mode_ff <= pwdata[0];
      end
   end

   // Front: framing state, one byte per cycle while the queue has room, pushes 0..2 results.
   clf_front #(
      .LINE_BUFFER_BYTES (LINE_BUFFER_BYTES)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .raw_mode (raw_mode_ff),
      .qstat    (qstat),
      .req_chan (req_chan),
      .push     (push)
   );

   // Queue decouples the two-result bursts from the single output.
   clf_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .qstat (qstat)
   );

   // Back: output register, takes the queue head when free or drained.
   clf_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .qstat    (qstat),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

   // Second result slot is filled only behind the first.
   a_push_order: assert property (@(posedge clock) disable iff (reset)
      push.valid[1] |-> push.valid[0])
      else $error("second result pushed without first");

   // No transaction is taken without room for two results.
   a_room: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |-> qstat.room)
      else $error("byte accepted without queue room");

   // Empty-line marker closes its line and carries no byte.
   a_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.empty_line)
         |-> (rsp_chan.last_of_line && rsp_chan.out_byte == 8'h00 && !rsp_chan.truncated))
      else $error("malformed empty-line result");

   // Nothing is shown on the result channel straight after reset.
   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_chan.valid)
      else $error("result valid after reset");

endmodule

>>> rtl/core/clf_front.sv
// Front: accepts bytes, runs the framing state and emits up to two results.
module clf_front #(
   parameter int LINE_BUFFER_BYTES = clf_pkg::CLF_LINE_BUFFER_BYTES
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   raw_mode,
   input  clf_pkg::clf_qstat_type qstat,
   clf_req_if.sink                req_chan,
   output clf_pkg::clf_push_type  push
);
   import clf_pkg::*;

   localparam int LEN_W = $clog2(LINE_BUFFER_BYTES);
   localparam logic [LEN_W-1:0] MAX_LINE = LEN_W'(LINE_BUFFER_BYTES - 1);

   clf_phase_type    phase_ff, phase_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic             held_valid_ff, held_valid_in;
   logic [7:0]       held_byte_ff, held_byte_in;
   clf_push_type     emit;
   logic             accept;

   function automatic clf_result_type clf_mk(logic [7:0] b, logic last,
                                             logic empty, logic trunc);
      clf_result_type r;
      r.out_byte     = b;
      r.last_of_line = last;
      r.empty_line   = empty;
      r.truncated    = trunc;
      return r;
   endfunction

   function automatic clf_push_type clf_add(clf_push_type p, clf_result_type r);
      clf_push_type q;
      q = p;
      if (!q.valid[0]) begin
         q.valid[0] = 1'b1;
         q.res0     = r;
      end else begin
         q.valid[1] = 1'b1;
         q.res1     = r;
      end
      return q;
   endfunction

   assign req_chan.ready = qstat.room;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      logic term;
      term          = (req_chan.in_byte == CLF_CR) || (req_chan.in_byte == CLF_LF);
      phase_in      = phase_ff;
      len_in        = len_ff;
      held_valid_in = held_valid_ff;
      held_byte_in  = held_byte_ff;
      emit          = '0;

      if (raw_mode) begin
         // raw: terminators kept, long lines split
         if (phase_in == PH_DISCARD) begin
            phase_in = PH_RUN;
         end
         if (phase_in == PH_RUN && !term) begin
            if (held_valid_in) emit = clf_add(emit, clf_mk(held_byte_in, 1'b1, 1'b0, 1'b0));
            held_valid_in = 1'b0;
            len_in        = '0;
         end
         if (len_in >= MAX_LINE) begin
            if (held_valid_in) emit = clf_add(emit, clf_mk(held_byte_in, 1'b1, 1'b0, 1'b0));
            held_valid_in = 1'b0;
            len_in        = '0;
         end
         if (len_in == '0) begin
            phase_in = term ? PH_RUN : PH_CONTENT;
         end else if (term) begin
            phase_in = PH_RUN;
         end
         if (held_valid_in) emit = clf_add(emit, clf_mk(held_byte_in, 1'b0, 1'b0, 1'b0));
         held_byte_in  = req_chan.in_byte;
         held_valid_in = 1'b1;
         len_in        = len_in + 1'b1;
      end else begin
         // cooked: terminators stripped, excess discarded
         if (term) begin
            if (phase_in == PH_START) begin
               emit = clf_add(emit, clf_mk(8'h00, 1'b1, 1'b1, 1'b0));
            end else begin
               if (held_valid_in) emit = clf_add(emit, clf_mk(held_byte_in, 1'b1, 1'b0, 1'b0));
               held_valid_in = 1'b0;
            end
            phase_in = PH_RUN;
            len_in   = '0;
         end else if (phase_in != PH_DISCARD) begin
            if (phase_in == PH_START || phase_in == PH_RUN) begin
               if (held_valid_in) emit = clf_add(emit, clf_mk(held_byte_in, 1'b1, 1'b0, 1'b0));
               held_valid_in = 1'b0;
               len_in        = '0;
            end
            if (len_in >= MAX_LINE) begin
               if (held_valid_in) emit = clf_add(emit, clf_mk(held_byte_in, 1'b1, 1'b0, 1'b1));
               held_valid_in = 1'b0;
               phase_in      = PH_DISCARD;
               len_in        = '0;
            end else begin
               if (held_valid_in) emit = clf_add(emit, clf_mk(held_byte_in, 1'b0, 1'b0, 1'b0));
               held_byte_in  = req_chan.in_byte;
               held_valid_in = 1'b1;
               len_in        = len_in + 1'b1;
               phase_in      = PH_CONTENT;
            end
         end
      end

      // chunk end closes a terminator run or a discard
      if (req_chan.chunk_end && (phase_in == PH_RUN || phase_in == PH_DISCARD)) begin
         if (held_valid_in) emit = clf_add(emit, clf_mk(held_byte_in, 1'b1, 1'b0, 1'b0));
         held_valid_in = 1'b0;
         phase_in      = PH_START;
         len_in        = '0;
      end
   end

   always_comb begin
      push       = emit;
      push.valid = emit.valid & {2{accept}};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_START;
         len_ff        <= '0;
         held_valid_ff <= 1'b0;
         held_byte_ff  <= 8'h00;
      end else if (accept) begin
         phase_ff      <= phase_in;
         len_ff        <= len_in;
         held_valid_ff <= held_valid_in;
         held_byte_ff  <= held_byte_in;
      end
   end

endmodule

>>> rtl/core/clf_queue.sv
// Result queue: takes up to two results a cycle, gives one.
module clf_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  clf_pkg::clf_push_type  push,
   input  logic                   pop,
   output clf_pkg::clf_result_type head,
   output clf_pkg::clf_qstat_type qstat
);
   import clf_pkg::*;

   localparam int PTR_W = $clog2(CLF_QUEUE_DEPTH);
   localparam int CNT_W = $clog2(CLF_QUEUE_DEPTH + 1);

   clf_result_type   entry_ff [CLF_QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [PTR_W-1:0] wr_next;
   logic [1:0]       n_push;

   assign n_push    = {1'b0, push.valid[0]} + {1'b0, push.valid[1]};
   assign wr_next   = wr_ptr_ff + 1'b1;
   assign wr_ptr_in = wr_ptr_ff + PTR_W'(n_push);
   assign rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
   assign count_in  = count_ff + CNT_W'(n_push) - CNT_W'(pop);

   assign head           = entry_ff[rd_ptr_ff];
   assign qstat.nonempty = (count_ff != '0);
   assign qstat.room     = (count_ff <= CNT_W'(CLF_QUEUE_DEPTH - 2));

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid[0]) entry_ff[wr_ptr_ff] <= push.res0;
      if (push.valid[1]) entry_ff[wr_next]   <= push.res1;
   end

endmodule

>>> rtl/core/clf_back.sv
// Back: output register that drains the queue onto the result channel.
module clf_back (
   input  logic                    clock,
   input  logic                    reset,
   input  clf_pkg::clf_result_type head,
   input  clf_pkg::clf_qstat_type  qstat,
   output logic                    pop,
   clf_rsp_if.source               rsp_chan
);
   import clf_pkg::*;

   logic           valid_ff;
   clf_result_type data_ff;

   assign pop = qstat.nonempty && (!valid_ff || rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (pop) begin
         valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) data_ff <= head;
   end

   assign rsp_chan.valid        = valid_ff;
   assign rsp_chan.out_byte     = data_ff.out_byte;
   assign rsp_chan.last_of_line = data_ff.last_of_line;
   assign rsp_chan.empty_line   = data_ff.empty_line;
   assign rsp_chan.truncated    = data_ff.truncated;

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for crlf_line_framer: directed, long-line and random framing.
module testbench;
   import clf_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // A line holds at most one byte less than the buffer.
   localparam int LINE_MAX_BYTES = CLF_LINE_BUFFER_BYTES - 1;
   // Generous cap on the run; the slowest legal run is several times shorter.
   localparam int CYCLE_LIMIT = 1_000_000;
   // Cycles let pass after the last expected transaction before a register write.
   localparam int SETTLE_CYCLES = 8;
   // Random byte transactions to aim for.
   localparam int RANDOM_ITEMS = 120;

   logic        clock = 1'b0;
   logic        reset;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   clf_req_if req_chan ();
   clf_rsp_if rsp_chan ();

   crlf_line_framer dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   always #2 clock = ~clock;

   // ---------------------------------------------------------------------
   // Framing predictor: our own copy of the framer state and raw_mode.
   // ---------------------------------------------------------------------
   bit             mode_raw;         // mirror of raw_mode
   logic [7:0]     held_data;        // byte held back to mark line ends
   bit             held_ok;
   logic [8:0]     line_len;         // bytes counted into the current line
   clf_phase_type  frame_state;
   int             step_results;     // results raised by the current byte

   // Expected result transactions, oldest first.
   clf_result_type pending_line_bytes[$];

   // Bookkeeping for the summary.
   int  error_count;
   int  cycle_count;
   int  bytes_sent;
   int  raw_bytes;
   int  results_seen;
   int  lines_seen;
   int  empty_seen;
   int  trunc_seen;
   int  random_items;
   bit  quiet;                       // both sides run without idling

   function void push_result(logic [7:0] b, bit last, bit empty, bit trunc);
      clf_result_type r;
      // Never more than two results from one byte.
      if (step_results < 2) begin
         r.out_byte     = b;
         r.last_of_line = last;
         r.empty_line   = empty;
         r.truncated    = trunc;
         pending_line_bytes.push_back(r);
         step_results++;
      end
   endfunction

   // Release the held byte as a mid-line byte and hold the new one.
   function void hold_new(logic [7:0] b);
      if (held_ok) push_result(held_data, 1'b0, 1'b0, 1'b0);
      held_data = b;
      held_ok   = 1'b1;
   endfunction

   // Release the held byte, if any, as the end of its line.
   function void close_line(bit trunc);
      if (held_ok) push_result(held_data, 1'b1, 1'b0, trunc);
      held_ok = 1'b0;
   endfunction

   function void frame_byte(logic [7:0] b, bit ce);
      bit term;
      term = (b == CLF_CR) || (b == CLF_LF);
      step_results = 0;
      if (mode_raw) begin
         // raw: discard phase counts as a terminator run
         if (frame_state == PH_DISCARD) frame_state = PH_RUN;
         if (frame_state == PH_RUN && !term) begin
            close_line(1'b0);
            line_len = '0;
         end
         // long raw line split: this byte opens a new line, not flagged
         if (line_len >= LINE_MAX_BYTES) begin
            close_line(1'b0);
            line_len = '0;
         end
         if (line_len == 0) frame_state = term ? PH_RUN : PH_CONTENT;
         else if (term) frame_state = PH_RUN;
         hold_new(b);
         line_len++;
      end else if (term) begin
         // cooked terminator: empty line at line start, else close the line
         if (frame_state == PH_START) push_result(8'h00, 1'b1, 1'b1, 1'b0);
         else close_line(1'b0);
         frame_state = PH_RUN;
         line_len    = '0;
      end else if (frame_state != PH_DISCARD) begin
         if (frame_state == PH_START || frame_state == PH_RUN) begin
            close_line(1'b0);
            line_len = '0;
         end
         if (line_len >= LINE_MAX_BYTES) begin
            // excess content: close as truncated, drop till terminator
            close_line(1'b1);
            frame_state = PH_DISCARD;
            line_len    = '0;
         end else begin
            hold_new(b);
            line_len++;
            frame_state = PH_CONTENT;
         end
      end
      // chunk end closes a run or a discard; open content carries over
      if (ce && (frame_state == PH_RUN || frame_state == PH_DISCARD)) begin
         close_line(1'b0);
         frame_state = PH_START;
         line_len    = '0;
      end
   endfunction

   // ---------------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------------
   task automatic report(input string what, input int got, input int want);
      error_count++;
      $display("%0t ns: %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
   endtask

   always @(posedge clock) begin
      clf_result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         results_seen++;
         if (pending_line_bytes.size() == 0) begin
            report("result with nothing expected", int'(rsp_chan.out_byte), 0);
         end else begin
            want = pending_line_bytes.pop_front();
            if (rsp_chan.out_byte !== want.out_byte)
               report("out_byte", int'(rsp_chan.out_byte), int'(want.out_byte));
            if (rsp_chan.last_of_line !== want.last_of_line)
               report("last_of_line", int'(rsp_chan.last_of_line),
                      int'(want.last_of_line));
            if (rsp_chan.empty_line !== want.empty_line)
               report("empty_line", int'(rsp_chan.empty_line), int'(want.empty_line));
            if (rsp_chan.truncated !== want.truncated)
               report("truncated", int'(rsp_chan.truncated), int'(want.truncated));
            if (want.last_of_line) lines_seen++;
            if (want.empty_line) empty_seen++;
            if (want.truncated) trunc_seen++;
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, pending_line_bytes.size());
         $display("crlf_line_framer: mismatch");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Result side: random stall drawn per transaction, none while quiet.
   // ---------------------------------------------------------------------
   initial begin
      int stall;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         stall = quiet ? 0 : $urandom_range(0, 19);
         if (stall != 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_chan.valid && rsp_chan.ready));
      end
   end

   // ---------------------------------------------------------------------
   // Byte side
   // ---------------------------------------------------------------------
   // Send one byte; valid stays high after acceptance so that back-to-back
   // transactions need no second assignment in the same step.
   task automatic send_stream_byte(input logic [7:0] b, input bit ce);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 19);
      @(negedge clock);
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.in_byte   <= b;
      req_chan.chunk_end <= ce;
      do @(posedge clock); while (!req_chan.ready);
      frame_byte(b, ce);
      bytes_sent++;
      if (mode_raw) raw_bytes++;
   endtask

   function automatic logic [7:0] text_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255)); while (b == CLF_CR || b == CLF_LF);
      return b;
   endfunction

   // n content bytes; chunk_end on roughly one in ce_odds (never when 0)
   task automatic send_text(input int n, input int ce_odds);
      bit ce;
      for (int i = 0; i < n; i++) begin
         ce = (ce_odds != 0) && ($urandom_range(1, ce_odds) == 1);
         send_stream_byte(text_byte(), ce);
      end
   endtask

   // Drop valid and wait for every expected transaction, then let the
   // pipeline settle (a byte may still be held with no result due).
   task automatic drain_stream();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (pending_line_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write raw_mode over APB, then read it back. Block must be idle.
   task automatic set_raw_mode(input bit raw);
      drain_stream();
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {CLF_REG_RAW_MODE, 2'b00};
      pwdata  <= {31'b0, raw};
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      mode_raw = raw;
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== {31'b0, raw}) report("raw_mode read back", int'(prdata), int'(raw));
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   // Cooked: empty lines, swallowed CR/LF runs, byte extremes, open lines
   // across chunk ends.
   task automatic test_cooked_basics();
      set_raw_mode(1'b0);
      send_stream_byte(CLF_LF, 1'b0);   // empty line at line start
      send_stream_byte(CLF_CR, 1'b0);   // same run, swallowed
      send_stream_byte(8'h00, 1'b0);
      send_stream_byte(8'hFF, 1'b0);
      send_stream_byte(CLF_CR, 1'b0);
      send_stream_byte(CLF_LF, 1'b1);   // chunk end closes the run
      send_stream_byte(CLF_CR, 1'b1);   // empty line, chunk end
      send_stream_byte(8'h41, 1'b1);    // content at chunk end stays open
      send_stream_byte(8'h42, 1'b0);
      send_stream_byte(CLF_LF, 1'b0);
      send_stream_byte(8'h43, 1'b0);    // new line straight after a run
      send_stream_byte(CLF_LF, 1'b1);
      send_stream_byte(8'h55, 1'b0);
      send_stream_byte(8'hAA, 1'b0);
      send_stream_byte(CLF_CR, 1'b0);
      send_stream_byte(CLF_LF, 1'b0);
      send_stream_byte(CLF_CR, 1'b1);
   endtask

   // Raw: terminators kept, a bare CR/LF line, open content at chunk end.
   task automatic test_raw_basics();
      set_raw_mode(1'b1);
      send_stream_byte(CLF_CR, 1'b0);   // line of only a CR/LF run
      send_stream_byte(CLF_LF, 1'b0);
      send_stream_byte(8'h61, 1'b0);
      send_stream_byte(8'hFF, 1'b0);
      send_stream_byte(8'h00, 1'b0);
      send_stream_byte(CLF_CR, 1'b0);
      send_stream_byte(CLF_LF, 1'b1);
      send_stream_byte(8'h71, 1'b1);    // stays open over the chunk end
      send_stream_byte(8'h72, 1'b0);
      send_stream_byte(CLF_LF, 1'b0);
      send_stream_byte(CLF_LF, 1'b0);
      send_stream_byte(CLF_CR, 1'b0);
      send_stream_byte(8'h73, 1'b1);
      send_stream_byte(8'h74, 1'b0);
      send_stream_byte(CLF_CR, 1'b1);
   endtask

   // Full line then truncation, raw mode seeing the discard as a run,
   // raw splitting at the line limit.
   task automatic test_long_lines();
      set_raw_mode(1'b0);
      quiet = 1'b1;
      send_text(LINE_MAX_BYTES, 0);     // full line, nothing dropped yet
      send_stream_byte(8'h6B, 1'b0);    // one over: closed as truncated
      send_stream_byte(8'h6C, 1'b0);    // discarded
      set_raw_mode(1'b1);
      send_text(LINE_MAX_BYTES, 0);     // raw takes the discard as a run
      send_stream_byte(8'h6D, 1'b0);    // split: opens a new line, not flagged
      quiet = 1'b0;
      send_stream_byte(CLF_CR, 1'b0);
      send_stream_byte(CLF_LF, 1'b1);
   endtask

   // raw_mode changed mid-line and mid-run; framing state is shared.
   task automatic test_mode_switch();
      set_raw_mode(1'b0);
      send_text(3, 0);
      set_raw_mode(1'b1);
      send_stream_byte(8'h64, 1'b0);
      send_stream_byte(CLF_CR, 1'b0);
      set_raw_mode(1'b0);
      send_stream_byte(CLF_LF, 1'b0);   // cooked, inside a raw run
      send_stream_byte(8'h65, 1'b0);
      send_stream_byte(CLF_LF, 1'b1);
      set_raw_mode(1'b1);
      send_stream_byte(8'h78, 1'b0);    // raw from line start
      send_stream_byte(8'h79, 1'b0);
      send_stream_byte(CLF_CR, 1'b0);
      set_raw_mode(1'b0);
      send_stream_byte(CLF_LF, 1'b0);
      send_stream_byte(8'h7A, 1'b0);
      send_stream_byte(CLF_LF, 1'b1);
   endtask

   // Mostly well-formed lines with random content and terminator runs,
   // some noise, over several mode settings.
   task automatic test_random_traffic();
      int phase_goal;
      int len;
      int pick;
      int run_len;
      bit ce;
      for (int ph = 0; ph < 6; ph++) begin
         set_raw_mode(ph == 0 ? 1'b0 : ph == 1 ? 1'b1 : 1'($urandom_range(0, 1)));
         quiet = (ph == 3);
         phase_goal = random_items + RANDOM_ITEMS / 6;
         while (random_items < phase_goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
               // noise: any byte, any chunk end
               len = $urandom_range(1, 8);
               for (int i = 0; i < len; i++)
                  send_stream_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
               random_items += len;
            end else begin
               if (pick < 75) len = $urandom_range(0, 12);
               else len = $urandom_range(13, 60);
               send_text(len, 20);
               run_len = $urandom_range(1, 3);
               for (int i = 0; i < run_len; i++) begin
                  ce = (i == run_len - 1) ? ($urandom_range(0, 3) == 0)
                                          : ($urandom_range(0, 19) == 0);
                  send_stream_byte($urandom_range(0, 1) ? CLF_CR : CLF_LF, ce);
               end
               random_items += len + run_len;
            end
            // sender holds off until every expected result is out
            if (ph == 2 && $urandom_range(0, 29) == 0) drain_stream();
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------
   initial begin
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.in_byte   = 8'h00;
      req_chan.chunk_end = 1'b0;
      psel               = 1'b0;
      penable            = 1'b0;
      pwrite             = 1'b0;
      paddr              = '0;
      pwdata             = '0;
      quiet              = 1'b0;
      mode_raw           = 1'b0;
      held_data          = 8'h00;
      held_ok            = 1'b0;
      line_len           = '0;
      frame_state        = PH_START;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_cooked_basics();
      test_raw_basics();
      test_long_lines();
      test_mode_switch();
      test_random_traffic();

      // wind down: everything expected must arrive, then a short tail
      drain_stream();
      repeat (16) @(posedge clock);

      $display("covered %0d bytes (%0d raw, %0d random) in %0d cycles",
               bytes_sent, raw_bytes, random_items, cycle_count);
      $display("checked %0d results: %0d lines, %0d empty, %0d truncated; %0d errors",
               results_seen, lines_seen, empty_seen, trunc_seen, error_count);
      if (error_count == 0 && pending_line_bytes.size() == 0) begin
         $display("crlf_line_framer: match");
      end else begin
         $display("crlf_line_framer: mismatch");
      end
      $finish;
   end

endmodule
